// ===== hdl/rsm_pkg.sv =====
package rsm_pkg;

  localparam int MAX_COLS = 64;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = COL_W + 1;
  localparam int ADDR_W = COL_W + 1;
  localparam int BANKS = 2;
  localparam int EXP_ENTRIES = 256;
  localparam int EXP_W = 17;
  localparam int SUM_W = 23;
  localparam int QUOT_W = 17;
  localparam int DIV_STEPS = QUOT_W;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);
  localparam logic signed [15:0] MOST_NEG = 16'sh8000;

  // Terms of the alternating series for exp(-1/16) in Q0.60, each one the
  // previous divided by 16k.
  localparam logic [63:0] EXP_ONE = 64'd1 << 60;
  localparam logic [63:0] EXP_T1  = EXP_ONE / 64'd16;
  localparam logic [63:0] EXP_T2  = EXP_T1 / 64'd32;
  localparam logic [63:0] EXP_T3  = EXP_T2 / 64'd48;
  localparam logic [63:0] EXP_T4  = EXP_T3 / 64'd64;
  localparam logic [63:0] EXP_T5  = EXP_T4 / 64'd80;
  localparam logic [63:0] EXP_T6  = EXP_T5 / 64'd96;
  localparam logic [63:0] EXP_T7  = EXP_T6 / 64'd112;
  localparam logic [63:0] EXP_T8  = EXP_T7 / 64'd128;
  localparam logic [63:0] EXP_T9  = EXP_T8 / 64'd144;
  localparam logic [63:0] EXP_T10 = EXP_T9 / 64'd160;
  localparam logic [63:0] EXP_T11 = EXP_T10 / 64'd176;
  localparam logic [63:0] EXP_T12 = EXP_T11 / 64'd192;
  localparam logic [63:0] EXP_T13 = EXP_T12 / 64'd208;
  localparam logic [63:0] EXP_T14 = EXP_T13 / 64'd224;
  localparam logic [63:0] EXP_T15 = EXP_T14 / 64'd240;
  localparam logic [63:0] EXP_POS = EXP_ONE + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8
                                    + EXP_T10 + EXP_T12 + EXP_T14;
  localparam logic [63:0] EXP_NEG = EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9
                                    + EXP_T11 + EXP_T13 + EXP_T15;
  localparam logic [63:0] EXP_STEP = EXP_POS - EXP_NEG;

  typedef struct packed {
    logic signed [15:0] value;
    logic               row_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] prob;
    logic        prob_last;
    logic        truncated;
  } out_item_t;

  typedef struct packed {
    logic                      bank;
    logic [CNT_W-1:0]          n;
    logic signed [15:0]        row_max;
    logic                      ovf;
  } row_desc_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic signed [15:0] data;
  } store_wr_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM_RD,
    B_SUM_ACC,
    B_DIV_RD,
    B_DIV_LD,
    B_DIV_RUN,
    B_EMIT
  } back_state_t;

  typedef logic [EXP_W-1:0] exp_lut_t [EXP_ENTRIES];

  // Table of round(65536 * exp(-i/16)), built in Q0.60 fixed point.
  function automatic exp_lut_t build_exp_lut();
    logic [63:0] v;
    logic [63:0] m;
    logic [63:0] a1;
    logic [63:0] a0;
    logic [63:0] b1;
    logic [63:0] b0;
    logic [63:0] mid;
    exp_lut_t    t;
    v = EXP_ONE;
    m = (64'd1 << 30) - 64'd1;
    for (int i = 0; i < EXP_ENTRIES; i++) begin
      t[i] = EXP_W'((v + (64'd1 << 43)) >> 44);
      a1 = v >> 30;
      a0 = v & m;
      b1 = EXP_STEP >> 30;
      b0 = EXP_STEP & m;
      mid = a1 * b0 + a0 * b1 + ((a0 * b0) >> 30);
      v = a1 * b1 + (mid >> 30);
    end
    return t;
  endfunction

  localparam exp_lut_t EXP_LUT = build_exp_lut();

endpackage

// ===== hdl/rsm_queue.sv =====
module rsm_queue import rsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  row_desc_t push_data,
  input  logic      pop,
  output row_desc_t head,
  output logic      empty,
  output logic      full
);

  row_desc_t  ent_r [BANKS];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;

  assign head  = ent_r[rptr_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'(BANKS));

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/rsm_front.sv =====
module rsm_front import rsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  logic      q_full,
  output logic      q_push,
  output row_desc_t q_data,
  output store_wr_t wr
);

  logic signed [15:0] max_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;
  logic               bank_r;
  logic               acc;
  logic               room;
  logic signed [15:0] max_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               ovf_nxt;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign room     = (cnt_r < CNT_W'(MAX_COLS));

  always_comb begin
    max_nxt = max_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (room) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (in_data.value > max_r) begin
        max_nxt = in_data.value;
      end
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign wr.en   = acc && room;
  assign wr.addr = {bank_r, cnt_r[COL_W-1:0]};
  assign wr.data = in_data.value;

  assign q_push         = acc && in_data.row_end;
  assign q_data.bank    = bank_r;
  assign q_data.n       = cnt_nxt;
  assign q_data.row_max = max_nxt;
  assign q_data.ovf     = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= MOST_NEG;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else if (acc) begin
      if (in_data.row_end) begin
        max_r  <= MOST_NEG;
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
        bank_r <= ~bank_r;
      end else begin
        max_r <= max_nxt;
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

endmodule

// ===== hdl/rsm_back.sv =====
module rsm_back import rsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  store_wr_t wr,
  input  row_desc_t desc,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic signed [15:0] mem [BANKS * MAX_COLS];
  logic signed [15:0] rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;

  back_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W:0]     rem_r, rem_nxt;
  logic [QUOT_W-1:0]  q_r, q_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [16:0]        diff;
  logic [EXP_W-1:0]   e_val;
  logic [SUM_W:0]     trial;
  logic               is_last;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_addr = {desc.bank, idx_r[COL_W-1:0]};
  assign rd_en   = (state_r == B_SUM_RD) || (state_r == B_DIV_RD);
  assign busy    = (state_r != B_IDLE);
  assign is_last = (idx_r + CNT_W'(1) == desc.n);

  assign diff  = 17'({desc.row_max[15], desc.row_max} - {rd_data_r[15], rd_data_r});
  assign e_val = (diff[16:12] == 5'd0) ? EXP_LUT[diff[11:4]] : '0;

  assign trial = (step_r == '0) ? rem_r : {rem_r[SUM_W-1:0], 1'b0};

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = B_SUM_RD;
        end
      end
      B_SUM_RD: begin
        state_nxt = B_SUM_ACC;
      end
      B_SUM_ACC: begin
        sum_nxt = sum_r + SUM_W'(e_val);
        if (is_last) begin
          idx_nxt   = '0;
          state_nxt = B_DIV_RD;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = B_SUM_RD;
        end
      end
      B_DIV_RD: begin
        state_nxt = B_DIV_LD;
      end
      B_DIV_LD: begin
        rem_nxt   = (SUM_W + 1)'(e_val);
        q_nxt     = '0;
        step_nxt  = '0;
        state_nxt = B_DIV_RUN;
      end
      B_DIV_RUN: begin
        if (trial >= {1'b0, sum_r}) begin
          rem_nxt = trial - {1'b0, sum_r};
          q_nxt   = {q_r[QUOT_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt   = {q_r[QUOT_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.prob      = q_r[QUOT_W-1] ? 16'hFFFF : q_r[15:0];
          out_data_nxt.prob_last = is_last;
          out_data_nxt.truncated = desc.ovf;
          if (is_last) begin
            q_pop     = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = B_DIV_RD;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/row_softmax.sv =====
// Channel   Ports                          Payload
// input     in_valid, in_ready, in_data    in_item_t: value, row_end
// result    out_valid, out_ready, out_data out_item_t: prob, prob_last, truncated
//
// An element can be taken every cycle while a row buffer is free; two row buffers
// let one row load while the previous one is processed.
// A row of n stored elements is summed with a read and an accumulate state per element;
// each result then takes a read, a load, the bit-per-cycle divider and an emit state.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result holds in the output register and stops the back end.
module row_softmax import rsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  logic      back_busy;
  row_desc_t q_in;
  row_desc_t q_head;
  store_wr_t wr;

  rsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in),
    .wr       (wr)
  );

  rsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .desc      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A row may only be queued when a row buffer is free.
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full)) else $error("row queue overfilled");

  // The back end works only on a queued row.
  a_busy_has_row: assert property (@(posedge clk) disable iff (!rst_n)
    back_busy |-> !q_empty) else $error("back end busy with no row");

  // A row is released only while a result is being produced.
  a_pop_emits: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_data.prob_last)) else $error("row released without last item");
`endif

endmodule

// ===== verif/tb_row_softmax.sv =====
module tb_row_softmax;
  import rsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS = 110;

  typedef struct {
    in_item_t    item;
    bit          pinned;
    logic [15:0] pinned_prob;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  stim_t     stim_q[$];
  out_item_t prob_q[$];
  int        send_ptr = 0;
  int        fail_count = 0;
  int        result_count = 0;
  int        row_count = 0;
  int        trunc_rows = 0;
  longint    cycle_count = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;

  logic [16:0]        exp_tab[256];
  logic signed [15:0] row_vals[MAX_COLS];
  logic signed [15:0] cur_max;
  int                 cur_n;
  bit                 cur_ovf;

  row_softmax u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
    longint unsigned msk;
    longint unsigned mid;
    msk = (64'd1 << 30) - 1;
    mid = (a >> 30) * (b & msk) + (a & msk) * (b >> 30) + (((a & msk) * (b & msk)) >> 30);
    return (a >> 30) * (b >> 30) + (mid >> 30);
  endfunction

  task automatic fill_exp_table();
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned ratio;
    longint unsigned v;
    term = 64'd1 << 60;
    pos = term;
    neg = 0;
    for (int k = 1; k < 16; k++) begin
      term = term / (64'd16 * k);
      if (k % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    ratio = pos - neg;
    v = 64'd1 << 60;
    for (int i = 0; i < 256; i++) begin
      exp_tab[i] = 17'((v + (64'd1 << 43)) >> 44);
      v = q60_mul(v, ratio);
    end
  endtask

  function automatic longint unsigned weight_of(logic signed [15:0] x);
    int d;
    d = int'(cur_max) - int'(x);
    return (d < 4096) ? exp_tab[d >> 4] : 0;
  endfunction

  task automatic clear_row();
    cur_max = MOST_NEG;
    cur_n = 0;
    cur_ovf = 1'b0;
  endtask

  // Accepted element: store it if the row has room and, on row end, queue the row's probabilities.
  task automatic predict_softmax(stim_t s);
    longint unsigned total;
    longint unsigned p;
    out_item_t r;
    if (cur_n < MAX_COLS) begin
      row_vals[cur_n] = s.item.value;
      cur_n++;
      if (s.item.value > cur_max) cur_max = s.item.value;
    end else begin
      cur_ovf = 1'b1;
    end
    if (!s.item.row_end) return;
    total = 0;
    for (int i = 0; i < cur_n; i++) total += weight_of(row_vals[i]);
    for (int i = 0; i < cur_n; i++) begin
      p = total != 0 ? (weight_of(row_vals[i]) << 16) / total : 0;
      r.prob = p > 65535 ? 16'hFFFF : 16'(p);
      r.prob_last = (i == cur_n - 1);
      r.truncated = cur_ovf;
      if (r.prob_last && s.pinned) r.prob = s.pinned_prob;
      prob_q.push_back(r);
    end
    row_count++;
    if (cur_ovf) trunc_rows++;
    clear_row();
  endtask

  task automatic report(string what, out_item_t got, out_item_t want);
    fail_count++;
    $display("mismatch %s: got prob=%0d last=%0b trunc=%0b, want prob=%0d last=%0b trunc=%0b",
             what, got.prob, got.prob_last, got.truncated,
             want.prob, want.prob_last, want.truncated);
  endtask

  task automatic add(logic signed [15:0] v, logic re, bit pin = 0, logic [15:0] pp = 0);
    stim_t s;
    s.item.value = v;
    s.item.row_end = re;
    s.pinned = pin;
    s.pinned_prob = pp;
    stim_q.push_back(s);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    int phase;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_softmax(stim_q[send_ptr]);
        send_ptr++;
      end
      if (out_valid && out_ready) begin
        result_count++;
        if (prob_q.size() == 0) begin
          report("unexpected result", out_data, '0);
        end else begin
          want = prob_q.pop_front();
          if (out_data.prob !== want.prob) report("prob", out_data, want);
          else if (out_data.prob_last !== want.prob_last) report("prob_last", out_data, want);
          else if (out_data.truncated !== want.truncated) report("truncated", out_data, want);
        end
      end
      phase = stim_q.size() > 0 ? (send_ptr * 4) / stim_q.size() : 0;
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 47; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 47; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (!in_valid || in_ready) begin
        if (send_ptr < stim_q.size() && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data <= stim_q[send_ptr].item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    int len;
    int total;
    int base;
    fill_exp_table();
    clear_row();
    add(16'sd0, 1'b1, 1, 16'hFFFF);
    add(16'sd32767, 1'b1, 1, 16'hFFFF);
    add(-16'sd32768, 1'b1, 1, 16'hFFFF);
    add(16'sd32767, 1'b0);
    add(-16'sd32768, 1'b1, 1, 16'd0);
    add(16'sd0, 1'b0);
    add(16'sd0, 1'b1);
    add(16'sd4096, 1'b0);
    add(16'sd1, 1'b0);
    add(16'sd0, 1'b1);
    for (int i = 0; i < 3; i++) add(-16'sd1, 1'b0);
    add(-16'sd1, 1'b1);
    add(16'sd100, 1'b0);
    add(-16'sd200, 1'b0);
    add(16'sh7F00, 1'b0);
    add(16'sd5, 1'b0);
    add(-16'sd5, 1'b0);
    add(16'sh5555, 1'b1);
    total = 0;
    while (total < RAND_ITEMS) begin
      case ($urandom_range(9))
        0: len = $urandom_range(70, 65);
        1, 2: len = $urandom_range(64, 7);
        default: len = $urandom_range(6, 1);
      endcase
      base = $urandom_range(65535) - 32768;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(3) == 0) begin
          add(16'($urandom_range(65535)), i == len - 1);
        end else begin
          add(16'(base + $urandom_range(2047) - 1024), i == len - 1);
        end
      end
      total += len;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (send_ptr == stim_q.size());
    wait (prob_q.size() == 0);
    repeat (300) @(posedge clk);
    $display("Sent %0d elements in %0d rows (%0d truncated), checked %0d probabilities.",
             stim_q.size(), row_count, trunc_rows, result_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
